>>> src/vwec_pkg.sv
// Package for the veto-window event counter.
// Holds the shared types, register indices and reset constants; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vwec_pkg;

    // Default width of the tick counter and of the stamps.
    localparam int TIME_BITS_DEF = 32;

    // Configuration registers.
    localparam int REG_BITS     = 20;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [REG_BITS-1:0] REG_RESET = REG_BITS'(500);

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_TICKS = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAMP_TICKS   = CFG_IDX_BITS'(1);

    localparam int EVT_TIME_BITS = 32;

    // Register values handed from the configuration block to the core.
    typedef struct packed {
        logic [REG_BITS-1:0] window_ticks;
        logic [REG_BITS-1:0] lamp_ticks;
    } t_cfg;

    // One result word.
    typedef struct packed {
        logic                     event_out;
        logic [EVT_TIME_BITS-1:0] event_time;
        logic                     trig_lamp;
        logic                     peak_lamp;
        logic                     log_lamp;
    } t_result;

endpackage

`default_nettype wire

>>> src/vwec_cfg.sv
// Configuration registers of the veto-window event counter.
// Depends on vwec_pkg for the register indices, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module vwec_cfg
    import vwec_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0] i_wr_index,
    input  wire logic [REG_BITS-1:0]     i_wr_data,
    output t_cfg                         o_cfg
);

    logic [REG_BITS-1:0] r_window_ticks;
    logic [REG_BITS-1:0] r_lamp_ticks;

    // Writes to an unknown index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= REG_RESET;
            r_lamp_ticks   <= REG_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_WINDOW_TICKS: begin
                    r_window_ticks <= i_wr_data;
                end
                CFG_LAMP_TICKS: begin
                    r_lamp_ticks <= i_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.window_ticks = r_window_ticks;
    assign o_cfg.lamp_ticks   = r_lamp_ticks;

endmodule

`default_nettype wire

>>> src/vwec_core.sv
// Tick state and decision logic of the veto-window event counter.
// Depends on vwec_pkg for the configuration and result types.
`timescale 1ns / 1ps
`default_nettype none

module vwec_core
    import vwec_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_trig_fall,
    input  wire logic i_peak_fall,
    input  wire t_cfg i_cfg,
    output t_result   o_result
);

    logic [TIME_BITS-1:0] r_now,  n_now;
    logic [TIME_BITS-1:0] r_trig_start, n_trig_start;
    logic [TIME_BITS-1:0] r_peak_start, n_peak_start;
    logic r_window_open, n_window_open;
    logic r_veto_seen,   n_veto_seen;
    logic r_trig_lamp,   n_trig_lamp;
    logic r_peak_lamp,   n_peak_lamp;
    logic r_log_lamp,    n_log_lamp;

    logic [TIME_BITS-1:0] trig_elapsed;
    logic [TIME_BITS-1:0] peak_elapsed;
    logic                 event_hit;

    // The peak edge is taken first, then the trigger edge, then the timeouts,
    // all of them against the stamps as they stand after the edges.
    always_comb begin
        n_now         = r_now + TIME_BITS'(1);
        n_trig_start  = r_trig_start;
        n_peak_start  = r_peak_start;
        n_window_open = r_window_open;
        n_veto_seen   = r_veto_seen;
        n_trig_lamp   = r_trig_lamp;
        n_peak_lamp   = r_peak_lamp;
        n_log_lamp    = r_log_lamp;
        event_hit     = 1'b0;

        if (i_peak_fall) begin
            n_veto_seen = 1'b1;
            if (!r_peak_lamp) begin
                n_peak_lamp  = 1'b1;
                n_peak_start = r_now;
            end
        end

        if (i_trig_fall && !r_window_open) begin
            n_window_open = 1'b1;
            n_trig_lamp   = 1'b1;
            n_trig_start  = r_now;
        end

        trig_elapsed = r_now - n_trig_start;
        peak_elapsed = r_now - n_peak_start;

        if (n_window_open && (trig_elapsed > TIME_BITS'(i_cfg.window_ticks))) begin
            if (!n_veto_seen) begin
                event_hit  = 1'b1;
                n_log_lamp = !r_log_lamp;
            end
            n_window_open = 1'b0;
            n_veto_seen   = 1'b0;
        end

        if (n_trig_lamp && (trig_elapsed > TIME_BITS'(i_cfg.lamp_ticks))) begin
            n_trig_lamp = 1'b0;
        end

        if (n_peak_lamp && (peak_elapsed > TIME_BITS'(i_cfg.lamp_ticks))) begin
            n_peak_lamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now         <= '0;
            r_trig_start  <= '0;
            r_peak_start  <= '0;
            r_window_open <= 1'b0;
            r_veto_seen   <= 1'b0;
            r_trig_lamp   <= 1'b0;
            r_peak_lamp   <= 1'b0;
            r_log_lamp    <= 1'b0;
        end else if (i_step) begin
            r_now         <= n_now;
            r_trig_start  <= n_trig_start;
            r_peak_start  <= n_peak_start;
            r_window_open <= n_window_open;
            r_veto_seen   <= n_veto_seen;
            r_trig_lamp   <= n_trig_lamp;
            r_peak_lamp   <= n_peak_lamp;
            r_log_lamp    <= n_log_lamp;
        end
    end

    assign o_result.event_out  = event_hit;
    assign o_result.event_time = event_hit ? EVT_TIME_BITS'(n_trig_start) : '0;
    assign o_result.trig_lamp  = n_trig_lamp;
    assign o_result.peak_lamp  = n_peak_lamp;
    assign o_result.log_lamp   = n_log_lamp;

`ifndef SYNTHESIS
    // Each processed tick advances the clock by exactly one.
    a_now_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_now == $past(r_now) + TIME_BITS'(1))
        else $error("tick counter did not advance by one");

    // Without a tick nothing may move the clock.
    a_now_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_now))
        else $error("tick counter moved without a tick");

    // An event always flips the log lamp.
    a_event_toggles_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && event_hit |=> r_log_lamp != $past(r_log_lamp))
        else $error("event without log lamp toggle");

    // Closing a window always clears the veto mark.
    a_close_clears_veto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_window_open && !n_window_open |=> !r_veto_seen)
        else $error("veto mark survived the window close");
`endif

endmodule

`default_nettype wire

>>> src/veto_window_event_counter.sv
// Top level of the veto-window event counter.
// Depends on vwec_pkg, vwec_cfg and vwec_core.
//
// Usage: each input word is one time tick carrying the trigger and peak
// falling-edge flags. A word is taken at a rising edge where i_in_valid is
// high and o_in_stall is low; a result word leaves at a rising edge where
// o_out_valid is high and i_out_stall is low. Every tick yields exactly one
// result word: the event flag and its trigger stamp, and the three lamps.
// The word is captured in the input register, the state update runs on it
// as it moves on and the result lands in the output register. Throughput is
// one word per cycle while the receiver does not stall; the state update of
// the core is combinational and holds two wrapping subtractions and compares.
// When the receiver stalls, the result register holds its word and the input
// register may still fill; once both are full, o_in_stall rises in the same
// cycle. The configuration port is always ready and takes a register index
// and data; writes to unknown indices are dropped. Reset, synchronous and
// active low, empties both registers, clears the tick counter, stamps and
// lamps, and loads both timing registers with 500 ticks.
`timescale 1ns / 1ps
`default_nettype none

module veto_window_event_counter
    import vwec_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Tick input channel.
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_trig_fall,
    input  wire logic                     i_peak_fall,
    // Result channel.
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_event_out,
    output logic [EVT_TIME_BITS-1:0]      o_event_time,
    output logic                          o_trig_lamp,
    output logic                          o_peak_lamp,
    output logic                          o_log_lamp,
    // Configuration write channel.
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [REG_BITS-1:0]      i_cfg_data
);

    t_cfg    cfg;
    t_result core_result;

    logic    r_in_vld;
    logic    r_trig_fall;
    logic    r_peak_fall;
    logic    r_out_vld;
    t_result r_result;
    logic    advance;

    // The pipeline moves whenever the output register is free or being drained.
    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !advance;
    assign o_cfg_ready = 1'b1;

    vwec_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The state only moves when the captured tick goes into the result register.
    vwec_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_in_vld && advance),
        .i_trig_fall (r_trig_fall),
        .i_peak_fall (r_peak_fall),
        .i_cfg       (cfg),
        .o_result    (core_result)
    );

    // Input register: the flags need no reset, only the valid bit does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_trig_fall <= i_trig_fall;
            r_peak_fall <= i_peak_fall;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_event_out  = r_result.event_out;
    assign o_event_time = r_result.event_time;
    assign o_trig_lamp  = r_result.trig_lamp;
    assign o_peak_lamp  = r_result.peak_lamp;
    assign o_log_lamp   = r_result.log_lamp;

endmodule

`default_nettype wire

>>> tb/veto_window_event_counter_tb.sv
// Testbench for the veto-window event counter: tick words in, one result word out per tick.
// Predicts every result word from its own copy of the state and checks it; needs vwec_pkg
// and the RTL of veto_window_event_counter.
`timescale 1ns / 1ps

module veto_window_event_counter_tb;
    import vwec_pkg::*;

    // No acceptance on any channel for this many cycles means the block has hung. The
    // slowest correct stretch is the long receiver hold plus a few idle cycles.
    localparam int QUIET_LIMIT = 1000;
    // Length of the receiver hold that fills the block and stalls its input.
    localparam int LONG_HOLD   = 64;

    // Register indices past the end of the list; writes to them must be dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = CFG_IDX_BITS'(3);

    typedef struct packed {
        logic trig;
        logic peak;
    } t_tick;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Tick channel, driven by the testbench.
    logic tick_valid = 1'b0;
    wire  tick_stall;
    logic tick_trig  = 1'b0;
    logic tick_peak  = 1'b0;

    // Result channel, stalled by the testbench.
    wire                     res_valid;
    logic                    res_stall = 1'b0;
    wire                     res_event;
    wire [EVT_TIME_BITS-1:0] res_time;
    wire                     res_trig_lamp;
    wire                     res_peak_lamp;
    wire                     res_log_lamp;

    // Configuration write channel.
    logic                    cfg_valid = 1'b0;
    wire                     cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]     cfg_data  = '0;

    // Tick words still to be offered, and result words predicted but not yet seen.
    t_tick   pending_q[$];
    t_result result_q[$];

    // Idling switches for the sender and the receiver, set per phase.
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;

    int errors = 0;

    // Predictor copy of the registers and of the block's state.
    logic [REG_BITS-1:0]      win_len;
    logic [REG_BITS-1:0]      lamp_len;
    logic [TIME_BITS_DEF-1:0] tick_now;
    logic [TIME_BITS_DEF-1:0] trig_stamp;
    logic [TIME_BITS_DEF-1:0] peak_stamp;
    logic                     win_open;
    logic                     vetoed;
    logic                     trig_lit;
    logic                     peak_lit;
    logic                     log_lit;

    // Driver bookkeeping.
    int    tx_wait = 0;
    bit    tick_held = 1'b0;
    t_tick next_tick;

    // Monitor bookkeeping.
    int      rx_wait = 0;
    t_result want;

    // Long receiver hold, kept by its own process.
    int   hold_cnt = 0;
    int   rx_count = 0;
    logic rx_hold  = 1'b0;

    int quiet_cycles = 0;

    veto_window_event_counter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (tick_valid),
        .o_in_stall   (tick_stall),
        .i_trig_fall  (tick_trig),
        .i_peak_fall  (tick_peak),
        .o_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .o_event_out  (res_event),
        .o_event_time (res_time),
        .o_trig_lamp  (res_trig_lamp),
        .o_peak_lamp  (res_peak_lamp),
        .o_log_lamp   (res_log_lamp),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // One tick of the counter. The peak edge is taken first, then the trigger edge, then the
    // window close and the two lamp timeouts, all measured against the tick time before it
    // advances. Elapsed time wraps, so it is zero in the tick of the stamp.
    function automatic t_result advance_tick(input t_tick tk);
        t_result                  r;
        logic [TIME_BITS_DEF-1:0] since_trig;
        logic [TIME_BITS_DEF-1:0] since_peak;
        r = '0;
        if (tk.peak) begin
            vetoed = 1'b1;
            if (!peak_lit) begin
                peak_lit   = 1'b1;
                peak_stamp = tick_now;
            end
        end
        // A trigger inside an open window changes nothing.
        if (tk.trig && !win_open) begin
            win_open   = 1'b1;
            trig_lit   = 1'b1;
            trig_stamp = tick_now;
        end
        since_trig = tick_now - trig_stamp;
        if (win_open && since_trig > TIME_BITS_DEF'(win_len)) begin
            // A veto from before the window opened still counts here.
            if (!vetoed) begin
                r.event_out  = 1'b1;
                r.event_time = trig_stamp[EVT_TIME_BITS-1:0];
                log_lit      = !log_lit;
            end
            win_open = 1'b0;
            vetoed   = 1'b0;
        end
        if (trig_lit && since_trig > TIME_BITS_DEF'(lamp_len)) begin
            trig_lit = 1'b0;
        end
        since_peak = tick_now - peak_stamp;
        if (peak_lit && since_peak > TIME_BITS_DEF'(lamp_len)) begin
            peak_lit = 1'b0;
        end
        tick_now    = tick_now + TIME_BITS_DEF'(1);
        r.trig_lamp = trig_lit;
        r.peak_lamp = peak_lit;
        r.log_lamp  = log_lit;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [EVT_TIME_BITS-1:0] exp_val,
                                 input logic [EVT_TIME_BITS-1:0] act_val);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field,
                 exp_val, act_val);
    endtask

    // Driver. A word is accepted at an edge where valid is high and stall is low; the
    // predictor runs on that word at once. A word stays on the port until it is taken, and
    // after each accepted word the sender may pause at random before the next when tx_idle is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_valid <= 1'b0;
            tx_wait     = 0;
            tick_held   = 1'b0;
            tick_now    = '0;
            trig_stamp  = '0;
            peak_stamp  = '0;
            win_open    = 1'b0;
            vetoed      = 1'b0;
            trig_lit    = 1'b0;
            peak_lit    = 1'b0;
            log_lit     = 1'b0;
        end else begin
            if (tick_valid && !tick_stall) begin
                result_q.push_back(advance_tick({tick_trig, tick_peak}));
                tick_held = 1'b0;
                tx_wait   = tx_idle ? $urandom_range(0, 5) : 0;
            end
            if (!tick_held) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    tick_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    next_tick   = pending_q.pop_front();
                    tick_trig  <= next_tick.trig;
                    tick_peak  <= next_tick.peak;
                    tick_valid <= 1'b1;
                    tick_held   = 1'b1;
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Predictor copy of the registers: follows every accepted configuration write.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_len  = REG_RESET;
            lamp_len = REG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WINDOW_TICKS: win_len  = cfg_data;
                CFG_LAMP_TICKS:   lamp_len = cfg_data;
                default: ;
            endcase
        end
    end

    // Long hold. Twice in the run, after the given number of accepted result words, the
    // receiver holds off for a long stretch so that the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold <= 1'b0;
            hold_cnt = 0;
            rx_count = 0;
        end else begin
            if (res_valid && !res_stall) begin
                rx_count++;
                if (rx_count == 300 || rx_count == 1100) begin
                    hold_cnt = LONG_HOLD;
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rx_hold <= 1'b1;
            end else begin
                rx_hold <= 1'b0;
            end
        end
    end

    // Monitor. Every accepted result word is checked field by field against the oldest
    // prediction. After each word the receiver may stall at random while rx_idle is set, and it
    // stalls throughout a long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_stall <= 1'b0;
            rx_wait    = 0;
        end else begin
            if (res_valid && !res_stall) begin
                if (result_q.size() == 0) begin
                    note_mismatch("unexpected word, event_time", '0, res_time);
                end else begin
                    want = result_q.pop_front();
                    if (res_event !== want.event_out)
                        note_mismatch("event_out", EVT_TIME_BITS'(want.event_out),
                                      EVT_TIME_BITS'(res_event));
                    if (res_time !== want.event_time)
                        note_mismatch("event_time", want.event_time, res_time);
                    if (res_trig_lamp !== want.trig_lamp)
                        note_mismatch("trig_lamp", EVT_TIME_BITS'(want.trig_lamp),
                                      EVT_TIME_BITS'(res_trig_lamp));
                    if (res_peak_lamp !== want.peak_lamp)
                        note_mismatch("peak_lamp", EVT_TIME_BITS'(want.peak_lamp),
                                      EVT_TIME_BITS'(res_peak_lamp));
                    if (res_log_lamp !== want.log_lamp)
                        note_mismatch("log_lamp", EVT_TIME_BITS'(want.log_lamp),
                                      EVT_TIME_BITS'(res_log_lamp));
                end
                rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
            end
            if (rx_hold) begin
                res_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((tick_valid && !tick_stall) || (res_valid && !res_stall) ||
                     (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Writes one register and returns on a rising edge after the write, with valid low.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every queued word has been taken and every prediction has been met.
    // Each word yields one result, so a short pause afterwards leaves the block idle.
    task automatic drain();
        while (pending_q.size() != 0 || tick_held || result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_ticks(input logic trig, input logic peak, input int count);
        t_tick tk;
        tk.trig = trig;
        tk.peak = peak;
        repeat (count) pending_q.push_back(tk);
    endtask

    // One phase of random ticks under one register setting. Triggers and vetoes come at the
    // given odds (one in trig_div, one in peak_div).
    task automatic run_phase(input logic [REG_BITS-1:0] win, input logic [REG_BITS-1:0] lamp,
                             input int trig_div, input int peak_div, input int count);
        t_tick tk;
        write_reg(CFG_WINDOW_TICKS, win);
        write_reg(CFG_LAMP_TICKS, lamp);
        for (int k = 0; k < count; k++) begin
            tk.trig = ($urandom_range(0, trig_div - 1) == 0);
            tk.peak = ($urandom_range(0, peak_div - 1) == 0);
            pending_q.push_back(tk);
        end
        drain();
    endtask

    initial begin
        t_tick tk;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: one trigger and a full 500-tick window with no veto, so it must close
        // with an event. Later triggers inside the window must be ignored.
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        queue_ticks(1'b1, 1'b0, 1);
        tk.peak = 1'b0;
        for (int k = 0; k < 505; k++) begin
            tk.trig = ($urandom_range(0, 3) == 0);
            pending_q.push_back(tk);
        end
        drain();

        // Short window and lamps, then the special cases one by one.
        write_reg(CFG_WINDOW_TICKS, REG_BITS'(3));
        write_reg(CFG_LAMP_TICKS, REG_BITS'(2));
        queue_ticks(1'b1, 1'b0, 1);     // a plain window that closes with an event
        queue_ticks(1'b0, 1'b0, 4);
        queue_ticks(1'b1, 1'b1, 1);     // veto in the very tick of the trigger
        queue_ticks(1'b0, 1'b0, 4);
        queue_ticks(1'b0, 1'b1, 1);     // veto outside a window carries into the next one
        queue_ticks(1'b0, 1'b0, 2);
        queue_ticks(1'b1, 1'b0, 1);
        queue_ticks(1'b0, 1'b0, 4);
        queue_ticks(1'b1, 1'b0, 2);     // second trigger while the window is open
        queue_ticks(1'b0, 1'b0, 4);
        drain();

        // Zero lengths: the window and the lamps end on the tick after their stamp.
        write_reg(CFG_WINDOW_TICKS, '0);
        write_reg(CFG_LAMP_TICKS, '0);
        queue_ticks(1'b1, 1'b0, 1);
        queue_ticks(1'b0, 1'b0, 1);
        queue_ticks(1'b1, 1'b1, 1);
        queue_ticks(1'b0, 1'b0, 1);
        queue_ticks(1'b0, 1'b1, 1);
        queue_ticks(1'b0, 1'b0, 1);
        drain();

        // Writes past the end of the register list must leave the zero lengths in place.
        write_reg(CFG_SPARE_A, REG_BITS'($urandom));
        write_reg(CFG_SPARE_B, REG_BITS'($urandom));
        queue_ticks(1'b1, 1'b0, 1);
        queue_ticks(1'b0, 1'b0, 2);
        drain();

        // Largest lengths: nothing closes and the lamps stay lit once on.
        run_phase('1, '1, 4, 4, 60);

        // Random phases with mostly short windows, so that many windows decide.
        for (int p = 0; p < 6; p++) begin
            tx_idle = (p % 3 != 0);
            rx_idle = (p % 2 != 0);
            case (p)
                0: run_phase(REG_BITS'(1), REG_BITS'(1), 4, 12, 200);
                1: run_phase(REG_BITS'($urandom_range(0, 8)), REG_BITS'($urandom_range(0, 8)),
                             6, 20, 200);
                2: run_phase(REG_BITS'($urandom_range(2, 20)), REG_BITS'($urandom_range(2, 20)),
                             10, 40, 200);
                3: run_phase(REG_BITS'($urandom_range(0, 15)), '0, 8, 30, 200);
                // Noise: edges on half the ticks, nearly every window vetoed.
                4: run_phase(REG_BITS'(3), REG_BITS'(5), 2, 2, 200);
                default: run_phase(REG_BITS'($urandom_range(1, 40)),
                                   REG_BITS'($urandom_range(1, 40)), 12, 60, 200);
            endcase
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
